@@ sv/assert_macros.svh @@
// Shared assertion macros for the IR transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/nectx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nectx_pkg;

	localparam int DUR_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int FRAME_BITS = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARK     = 4'd7;

	// Reset durations in 50 us ticks
	localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 12'd180;
	localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 12'd90;
	localparam logic [DUR_W-1:0] RST_BIT_MARK     = 12'd11;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 12'd11;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 12'd34;
	localparam logic [DUR_W-1:0] RST_REPEAT_SPACE = 12'd50;
	localparam logic [DUR_W-1:0] RST_REPEAT_GAP   = 12'd1899;
	localparam logic [DUR_W-1:0] RST_END_MARK     = 12'd5;

	// Item kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef struct packed {
		logic [DUR_W-1:0] leader_mark_ticks;
		logic [DUR_W-1:0] leader_space_ticks;
		logic [DUR_W-1:0] bit_mark_ticks;
		logic [DUR_W-1:0] zero_space_ticks;
		logic [DUR_W-1:0] one_space_ticks;
		logic [DUR_W-1:0] repeat_space_ticks;
		logic [DUR_W-1:0] repeat_gap_ticks;
		logic [DUR_W-1:0] end_mark_ticks;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] address;
		logic [7:0] command;
		logic       key_held;
	} item_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic frame_done;
	} res_t;

endpackage

`default_nettype wire

@@ sv/nectx_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nectx_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [nectx_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [nectx_pkg::DUR_W-1:0]     wr_data,
	output nectx_pkg::cfg_t                      cfg
);
	import nectx_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_mark_ticks  <= RST_LEADER_MARK;
			cfg_q.leader_space_ticks <= RST_LEADER_SPACE;
			cfg_q.bit_mark_ticks     <= RST_BIT_MARK;
			cfg_q.zero_space_ticks   <= RST_ZERO_SPACE;
			cfg_q.one_space_ticks    <= RST_ONE_SPACE;
			cfg_q.repeat_space_ticks <= RST_REPEAT_SPACE;
			cfg_q.repeat_gap_ticks   <= RST_REPEAT_GAP;
			cfg_q.end_mark_ticks     <= RST_END_MARK;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LEADER_MARK:  cfg_q.leader_mark_ticks  <= wr_data;
				REG_LEADER_SPACE: cfg_q.leader_space_ticks <= wr_data;
				REG_BIT_MARK:     cfg_q.bit_mark_ticks     <= wr_data;
				REG_ZERO_SPACE:   cfg_q.zero_space_ticks   <= wr_data;
				REG_ONE_SPACE:    cfg_q.one_space_ticks    <= wr_data;
				REG_REPEAT_SPACE: cfg_q.repeat_space_ticks <= wr_data;
				REG_REPEAT_GAP:   cfg_q.repeat_gap_ticks   <= wr_data;
				REG_END_MARK:     cfg_q.end_mark_ticks     <= wr_data;
				default: ;        // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/nectx_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nectx_fsm #(
	parameter int COUNT_WIDTH = 12
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire nectx_pkg::cfg_t  cfg,
	input  wire logic   step,
	input  wire nectx_pkg::item_t item,
	output nectx_pkg::res_t  res
);
	import nectx_pkg::*;

	localparam int CMP_W = COUNT_WIDTH + 1;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_LEAD_MARK  = 4'd1,
		PH_LEAD_SPACE = 4'd2,
		PH_BIT_MARK   = 4'd3,
		PH_BIT_SPACE  = 4'd4,
		PH_REP_MARK   = 4'd5,
		PH_REP_SPACE  = 4'd6,
		PH_REP_BIT    = 4'd7,
		PH_REP_GAP    = 4'd8,
		PH_END_MARK   = 4'd9
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [5:0]             bit_q, bit_d;
	logic [FRAME_BITS-1:0]  shift_q, shift_d;
	res_t                   res_q, res_d;

	logic [DUR_W-1:0] len_raw;
	logic [DUR_W-1:0] len_eff;
	logic [CMP_W-1:0] tick_next;
	logic [5:0]       bit_next;
	logic             phase_end;

	// Duration of the current phase; a zero register acts as one tick
	always_comb begin
		unique case (phase_q)
			PH_LEAD_MARK:  len_raw = cfg.leader_mark_ticks;
			PH_LEAD_SPACE: len_raw = cfg.leader_space_ticks;
			PH_BIT_MARK:   len_raw = cfg.bit_mark_ticks;
			PH_BIT_SPACE:  len_raw = shift_q[FRAME_BITS-1] ? cfg.one_space_ticks
			                                               : cfg.zero_space_ticks;
			PH_REP_MARK:   len_raw = cfg.leader_mark_ticks;
			PH_REP_SPACE:  len_raw = cfg.repeat_space_ticks;
			PH_REP_BIT:    len_raw = cfg.bit_mark_ticks;
			PH_REP_GAP:    len_raw = cfg.repeat_gap_ticks;
			default:       len_raw = cfg.end_mark_ticks;
		endcase
		len_eff   = (len_raw == '0) ? DUR_W'(1) : len_raw;
		tick_next = CMP_W'(tick_q) + CMP_W'(1);
		phase_end = (tick_next >= CMP_W'(len_eff)) || (tick_q == '1);
		bit_next  = bit_q + 6'd1;
	end

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		res_d   = '0;

		if (item.kind == KIND_START) begin
			if (phase_q == PH_IDLE) begin
				shift_d = {item.address, ~item.address, item.command, ~item.command};
				bit_d   = '0;
				tick_d  = '0;
				phase_d = PH_LEAD_MARK;
			end
		end else if (phase_q != PH_IDLE) begin
			if (phase_end) begin
				tick_d = '0;
				unique case (phase_q)
					PH_LEAD_MARK:  phase_d = PH_LEAD_SPACE;
					PH_LEAD_SPACE: phase_d = PH_BIT_MARK;
					PH_BIT_MARK:   phase_d = PH_BIT_SPACE;
					PH_BIT_SPACE: begin
						shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
						bit_d   = bit_next;
						if (bit_next < 6'(FRAME_BITS))
							phase_d = PH_BIT_MARK;
						else
							phase_d = item.key_held ? PH_REP_MARK : PH_END_MARK;
					end
					PH_REP_MARK:   phase_d = PH_REP_SPACE;
					PH_REP_SPACE:  phase_d = PH_REP_BIT;
					PH_REP_BIT:    phase_d = PH_REP_GAP;
					PH_REP_GAP:    phase_d = item.key_held ? PH_REP_MARK : PH_END_MARK;
					default: begin
						phase_d          = PH_IDLE;
						res_d.frame_done = 1'b1;
					end
				endcase
			end else begin
				tick_d = tick_next[COUNT_WIDTH-1:0];
			end
		end

		res_d.carrier_on = (phase_d == PH_LEAD_MARK) || (phase_d == PH_BIT_MARK) ||
		                   (phase_d == PH_REP_MARK) || (phase_d == PH_REP_BIT) ||
		                   (phase_d == PH_END_MARK);
		res_d.busy_res   = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			res_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			res_q   <= res_d;
		end
	end

	assign res = res_q;

	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, res_q.frame_done, phase_q == PH_IDLE)
	`ASSERT_IMPLIES(a_idle_count, clk, arst_n, phase_q == PH_IDLE, tick_q == '0)
	`ASSERT_ALWAYS(a_bit_range, clk, arst_n, bit_q <= 6'(FRAME_BITS))
	`ASSERT_IMPLIES(a_rep_after_frame, clk, arst_n,
		(phase_q == PH_REP_MARK) || (phase_q == PH_REP_GAP),
		bit_q == 6'(FRAME_BITS))
	`ASSERT_NEXT(a_hold_no_step, clk, arst_n, !step, $stable(phase_q) && $stable(res_q))

endmodule

`default_nettype wire

@@ sv/nec_ir_frame_transmitter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir  Handshake              Payload
// s_axis       in   s_axis_tvalid/tready   tdata: address, command, key_held; tuser: kind
// m_axis       out  m_axis_tvalid/tready   tdata: carrier_on, busy_res, frame_done
// cfg          in   cfg_valid/cfg_ready    cfg_index, cfg_data (duration in 50 us ticks)
//
// One request per clock cycle is sustained while m_axis takes results; each request shows
// its result on m_axis after the input register, then phase logic into the result register.
// arst_n clears the phase machine and both pipeline valids and loads the default
// durations. A stalled m_axis holds its result; the input register then fills and
// s_axis_tready drops until the result is taken.

module nec_ir_frame_transmitter #(
	parameter int COUNT_WIDTH = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [7:0] address, [15:8] command, [16] key_held
	input  wire logic        s_axis_tuser,  // [0] kind: 0 tick, 1 start frame
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [0] carrier_on, [1] busy_res, [2] frame_done
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [nectx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nectx_pkg::DUR_W-1:0]     cfg_data
);
	import nectx_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  in_accept;
	logic  advance;
	res_t  res;

	// Move the held request into the phase logic when the result slot frees up
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset: it is only looked at behind valid_s1
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.kind     <= s_axis_tuser;
			item_s1.address  <= s_axis_tdata[7:0];
			item_s1.command  <= s_axis_tdata[15:8];
			item_s1.key_held <= s_axis_tdata[16];
		end
	end

	nectx_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	nectx_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, res.frame_done, res.busy_res, res.carrier_on};

endmodule

`default_nettype wire

@@ tb/nec_ir_frame_transmitter_tb.sv @@
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_tb;

	import nectx_pkg::*;

	localparam int          HALF_PERIOD = 5;
	localparam int          RESET_CYCLES = 5;
	localparam int unsigned QUIET_LIMIT = 1000;	// cycles with no handshake at all
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CALM_TAIL = 120;	// requests left when idling stops

	// Registers in index order, so a loop can walk them by name
	localparam logic [CFG_IDX_W-1:0] DUR_REGS [8] = '{
		REG_LEADER_MARK, REG_LEADER_SPACE, REG_BIT_MARK, REG_ZERO_SPACE,
		REG_ONE_SPACE, REG_REPEAT_SPACE, REG_REPEAT_GAP, REG_END_MARK
	};

	// Envelope segments of the predicted transmission
	typedef enum logic [3:0] {
		SEG_IDLE,
		SEG_LEADER_MARK,
		SEG_LEADER_SPACE,
		SEG_BIT_MARK,
		SEG_BIT_SPACE,
		SEG_RPT_MARK,
		SEG_RPT_SPACE,
		SEG_RPT_BIT,
		SEG_RPT_GAP,
		SEG_END_MARK
	} segment_e;

	// One pending request: either an input item or a duration register write
	typedef struct {
		logic                 is_write;
		item_t                item;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DUR_W-1:0]     reg_val;
	} tx_request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;	// [7:0] address, [15:8] command, [16] key_held
	logic                 s_axis_tuser = 1'b0;	// [0] kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;	// [0] carrier_on, [1] busy_res, [2] frame_done
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]     cfg_data = '0;

	tx_request_t request_q[$];
	res_t        envelope_q[$];	// expected results, oldest first
	int unsigned mismatch_count = 0;

	// Predicted transmitter state and durations, indexed by register index
	logic [DUR_W-1:0] dur_ticks [0:15];
	segment_e         seg;
	logic [11:0]      tick_cnt;
	logic [5:0]       bits_sent;
	logic [31:0]      frame_bits;

	nec_ir_frame_transmitter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Advance the predicted envelope by one request and return the result it yields.
	function automatic res_t advance_envelope(item_t it);
		res_t        r;
		logic [12:0] span;
		logic [12:0] nxt;
		r.frame_done = 1'b0;
		if (it.kind == KIND_START) begin
			// a start only takes effect from idle; key_held is ignored here
			if (seg == SEG_IDLE) begin
				frame_bits = {it.address, ~it.address, it.command, ~it.command};
				bits_sent = '0;
				tick_cnt = '0;
				seg = SEG_LEADER_MARK;
			end
		end else if (seg != SEG_IDLE) begin
			case (seg)
				SEG_LEADER_MARK, SEG_RPT_MARK: span = {1'b0, dur_ticks[REG_LEADER_MARK]};
				SEG_LEADER_SPACE:              span = {1'b0, dur_ticks[REG_LEADER_SPACE]};
				SEG_BIT_MARK, SEG_RPT_BIT:     span = {1'b0, dur_ticks[REG_BIT_MARK]};
				SEG_BIT_SPACE: begin
					span = {1'b0, frame_bits[31] ? dur_ticks[REG_ONE_SPACE]
						: dur_ticks[REG_ZERO_SPACE]};
				end
				SEG_RPT_SPACE:                 span = {1'b0, dur_ticks[REG_REPEAT_SPACE]};
				SEG_RPT_GAP:                   span = {1'b0, dur_ticks[REG_REPEAT_GAP]};
				default:                       span = {1'b0, dur_ticks[REG_END_MARK]};
			endcase
			// a zero duration behaves as a single tick
			if (span == '0)
				span = 13'd1;
			nxt = {1'b0, tick_cnt} + 13'd1;
			if (nxt >= span || tick_cnt == '1) begin
				tick_cnt = '0;
				case (seg)
					SEG_LEADER_MARK:  seg = SEG_LEADER_SPACE;
					SEG_LEADER_SPACE: seg = SEG_BIT_MARK;
					SEG_BIT_MARK:     seg = SEG_BIT_SPACE;
					SEG_BIT_SPACE: begin
						frame_bits = frame_bits << 1;
						bits_sent = bits_sent + 6'd1;
						if (bits_sent < 6'(FRAME_BITS))
							seg = SEG_BIT_MARK;
						else
							seg = it.key_held ? SEG_RPT_MARK : SEG_END_MARK;
					end
					SEG_RPT_MARK:     seg = SEG_RPT_SPACE;
					SEG_RPT_SPACE:    seg = SEG_RPT_BIT;
					SEG_RPT_BIT:      seg = SEG_RPT_GAP;
					SEG_RPT_GAP:      seg = it.key_held ? SEG_RPT_MARK : SEG_END_MARK;
					default: begin
						seg = SEG_IDLE;
						r.frame_done = 1'b1;
					end
				endcase
			end else begin
				tick_cnt = nxt[11:0];
			end
		end
		r.carrier_on = seg inside {SEG_LEADER_MARK, SEG_BIT_MARK, SEG_RPT_MARK, SEG_RPT_BIT,
			SEG_END_MARK};
		r.busy_res = (seg != SEG_IDLE);
		return r;
	endfunction

	task automatic queue_item(logic kind, logic [7:0] addr, logic [7:0] cmd, logic key);
		tx_request_t q;
		q.is_write = 1'b0;
		q.item = '{kind: kind, address: addr, command: cmd, key_held: key};
		q.reg_idx = '0;
		q.reg_val = '0;
		request_q.push_back(q);
	endtask

	// Queue a write of every duration register with a value drawn from [lo, hi].
	task automatic queue_durations(int unsigned lo, int unsigned hi);
		tx_request_t q;
		q.is_write = 1'b1;
		q.item = '0;
		foreach (DUR_REGS[i]) begin
			q.reg_idx = DUR_REGS[i];
			q.reg_val = DUR_W'($urandom_range(hi, lo));
			request_q.push_back(q);
		end
	endtask

	// Queue a start followed by a run of ticks; key_held leans toward a per-frame bias
	// so that some frames end at once and others run through several repeat codes.
	task automatic queue_frame(int unsigned n_ticks);
		int unsigned hold_odds;
		hold_odds = $urandom_range(0, 3);
		queue_item(KIND_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
		for (int unsigned t = 0; t < n_ticks; t++) begin
			// drop in an occasional stray start, ignored while the frame is busy
			if ($urandom_range(0, 24) == 0)
				queue_item(KIND_START, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else
				queue_item(KIND_TICK, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) < hold_odds));
		end
	endtask

	// Driver: issue requests and register writes from request_q, predicting each
	// accepted request. Writes wait until every expected result has been taken.
	item_t       held_item;
	int unsigned send_gap = 0;

	always @(posedge clk or negedge arst_n) begin : driver
		logic        nxt_valid;
		logic        nxt_write;
		tx_request_t head;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			send_gap = 0;
			held_item = '0;
			// load the reset durations and clear the predicted transmitter
			dur_ticks[REG_LEADER_MARK] = RST_LEADER_MARK;
			dur_ticks[REG_LEADER_SPACE] = RST_LEADER_SPACE;
			dur_ticks[REG_BIT_MARK] = RST_BIT_MARK;
			dur_ticks[REG_ZERO_SPACE] = RST_ZERO_SPACE;
			dur_ticks[REG_ONE_SPACE] = RST_ONE_SPACE;
			dur_ticks[REG_REPEAT_SPACE] = RST_REPEAT_SPACE;
			dur_ticks[REG_REPEAT_GAP] = RST_REPEAT_GAP;
			dur_ticks[REG_END_MARK] = RST_END_MARK;
			seg = SEG_IDLE;
			tick_cnt = '0;
			bits_sent = '0;
			frame_bits = '0;
		end else begin
			nxt_valid = s_axis_tvalid;
			nxt_write = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				envelope_q.push_back(advance_envelope(held_item));
				nxt_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				dur_ticks[cfg_index] = cfg_data;
				nxt_write = 1'b0;
			end
			if (!nxt_valid && !nxt_write) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (request_q.size() != 0) begin
					head = request_q[0];
					if (head.is_write) begin
						// hold the write until the block has nothing in flight
						if (envelope_q.size() == 0) begin
							void'(request_q.pop_front());
							cfg_index <= head.reg_idx;
							cfg_data <= head.reg_val;
							nxt_write = 1'b1;
						end
					end else begin
						void'(request_q.pop_front());
						held_item = head.item;
						s_axis_tdata <= {7'd0, head.item.key_held, head.item.command,
							head.item.address};
						s_axis_tuser <= head.item.kind;
						nxt_valid = 1'b1;
						if (request_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
							send_gap = $urandom_range(1, 10);
					end
				end
			end
			s_axis_tvalid <= nxt_valid;
			cfg_valid <= nxt_write;
		end
	end

	// Monitor: stall the result side in bursts and compare every result with the
	// oldest prediction, field by field.
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (envelope_q.size() == 0) begin
					$display("%0t: result with no request pending: expected none, actual %b",
						$time, m_axis_tdata[2:0]);
					mismatch_count++;
				end else begin
					want = envelope_q.pop_front();
					if (m_axis_tdata[0] !== want.carrier_on) begin
						$display("%0t: carrier_on expected %b actual %b",
							$time, want.carrier_on, m_axis_tdata[0]);
						mismatch_count++;
					end
					if (m_axis_tdata[1] !== want.busy_res) begin
						$display("%0t: busy_res expected %b actual %b",
							$time, want.busy_res, m_axis_tdata[1]);
						mismatch_count++;
					end
					if (m_axis_tdata[2] !== want.frame_done) begin
						$display("%0t: frame_done expected %b actual %b",
							$time, want.frame_done, m_axis_tdata[2]);
						mismatch_count++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (request_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 9);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no handshake of any kind happens for too long.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[nec_ir_frame_transmitter] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// Reset durations: tick while idle, start with key_held set (ignored),
		// start while busy (ignored), extremes of the data bytes.
		queue_item(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
		queue_item(KIND_START, 8'hFF, 8'h00, 1'b1);
		queue_item(KIND_START, 8'h00, 8'hFF, 1'b0);
		queue_item(KIND_TICK, 8'h00, 8'h00, 1'b0);
		queue_item(KIND_TICK, 8'hA5, 8'h5A, 1'b1);
		// run past the end of the default leader mark
		for (int i = 0; i < 190; i++)
			queue_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));

		// Shortest durations; the frame in progress finishes under them.
		queue_durations(1, 1);
		queue_item(KIND_TICK, 8'h00, 8'h00, 1'b0);
		queue_frame(90);

		// Zero durations act as one tick.
		queue_durations(0, 0);
		queue_frame(70);

		// Longest durations: hold a long phase for a stretch of ticks.
		queue_durations(4095, 4095);
		queue_item(KIND_START, 8'h00, 8'hFF, 1'b0);
		for (int i = 0; i < 30; i++)
			queue_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				1'b0);

		// Small random durations; a frame in progress carries on under them.
		for (int p = 0; p < 2; p++) begin
			queue_durations(1, 3);
			queue_frame($urandom_range(30, 50));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || s_axis_tvalid || cfg_valid || envelope_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && envelope_q.size() == 0)
			$display("[nec_ir_frame_transmitter] OK");
		else
			$display("[nec_ir_frame_transmitter] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/nectx_pkg.sv
sv/nectx_cfg.sv
sv/nectx_fsm.sv
sv/nec_ir_frame_transmitter.sv
tb/nec_ir_frame_transmitter_tb.sv
